### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, command codes and round constants for the SHA-256 core.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_ABSORB = 2'd1,
        CMD_DIGEST = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // which block the compression works on
    typedef enum logic [1:0] {
        JOB_ABSORB,
        JOB_PAD1,
        JOB_PAD2
    } t_job;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    localparam t_hash INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

### sv/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for command words and digest words.
// ----------------------------------------------------------------------------
interface sha256_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha256_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round, reused 64 times.
// ----------------------------------------------------------------------------
module sha256_round (
    input  sha256_pkg::t_hash i_vars,
    input  sha256_pkg::t_word i_w,
    input  sha256_pkg::t_word i_k,
    output sha256_pkg::t_hash o_vars
);
    sha256_pkg::t_word s0, s1, ch, maj, t1, t2;

    always_comb begin
        s1  = {i_vars[4][5:0], i_vars[4][31:6]} ^ {i_vars[4][10:0], i_vars[4][31:11]}
            ^ {i_vars[4][24:0], i_vars[4][31:25]};
        ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        t1  = i_vars[7] + s1 + ch + i_k + i_w;
        s0  = {i_vars[0][1:0], i_vars[0][31:2]} ^ {i_vars[0][12:0], i_vars[0][31:13]}
            ^ {i_vars[0][21:0], i_vars[0][31:22]};
        maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        t2  = s0 + maj;
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end
endmodule

### sv/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core
// Absorbs message bytes, compresses full blocks, emits padded digests.
// ----------------------------------------------------------------------------
// channel   dir  words                       notes
// i_cmd     in   command, data_byte          begin / absorb / digest
// o_dig     out  digest_word, word_index,    eight words per digest command
//                last_word
//
// Begin, unused commands and most absorbs finish once accepted. The 64th byte of a
// block starts a compression: a load phase (one read prime, then one shift
// per block byte), 64 rounds on the shared round unit and a fold, all with
// i_cmd.ready low. A digest runs one or two compressions on a scratch hash,
// then offers its eight words, one per cycle while o_dig.ready is high.
// Synchronous active-low reset loads the initial hash; the block buffer
// needs no clearing. i_cmd.ready stays low while a command is in progress.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
    input  logic i_clk,
    input  logic i_rst_n,
    sha256_cmd_if.sink   i_cmd,
    sha256_dig_if.source o_dig
);
    sha256_pkg::t_state r_state, n_state;
    sha256_pkg::t_job   r_job, n_job;

    logic [7:0]  r_blk [64];        // block buffer
    logic [5:0]  r_held;
    logic [63:0] r_bitlen;
    sha256_pkg::t_hash r_hash, r_scr, r_vars;
    sha256_pkg::t_word r_win [16];  // schedule window
    logic [5:0]  r_cnt;
    logic        r_tail;            // last load step, byte 63
    logic [2:0]  r_oidx;
    logic [7:0]  r_rd;              // registered buffer read
    logic [63:0] r_len;             // message bit length for the digest

    logic acc;
    sha256_pkg::t_word w_sched, w_cur, w_load, k_cur;
    sha256_pkg::t_hash vars_nxt, base;
    logic [5:0] rd_addr;
    logic [7:0] pad_byte;
    logic [5:0] byte_pos;

    assign acc = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == sha256_pkg::ST_IDLE);

    // load phase: one byte a cycle, bytes shift through the whole window
    assign rd_addr = r_cnt;
    always_ff @(posedge i_clk) begin
        if (acc && i_cmd.command == sha256_pkg::CMD_ABSORB)
            r_blk[r_held] <= i_cmd.data_byte;
        r_rd <= r_blk[rd_addr];
    end

    // padded byte from the registered read (position = r_cnt - 1, 63 on tail)
    assign byte_pos = r_tail ? 6'd63 : r_cnt - 6'd1;
    always_comb begin
        pad_byte = r_rd;
        if (r_job != sha256_pkg::JOB_ABSORB) begin
            if (r_job == sha256_pkg::JOB_PAD2 || byte_pos > r_held)
                pad_byte = 8'h00;
            else if (byte_pos == r_held)
                pad_byte = 8'h80;
            // length field in the final block
            if (byte_pos >= 6'd56 && (r_job == sha256_pkg::JOB_PAD2
                || r_held < 6'd56))
                pad_byte = r_len[8'd63 - {2'b0, byte_pos[2:0], 3'b0} -: 8];
        end
    end

    assign w_load = {r_win[15][23:0], pad_byte};

    always_comb begin
        sha256_pkg::t_word w2, w15;
        w2  = r_win[14];
        w15 = r_win[1];
        w_sched = ({w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10))
                + r_win[9]
                + ({w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3))
                + r_win[0];
    end
    assign w_cur = (r_cnt < 6'd16) ? r_win[r_cnt[3:0]] : w_sched;
    assign k_cur = sha256_pkg::round_k(r_cnt);
    assign base  = (r_job == sha256_pkg::JOB_ABSORB) ? r_hash
                 : (r_job == sha256_pkg::JOB_PAD1) ? r_hash : r_scr;

    sha256_round u_round (.i_vars(r_vars), .i_w(w_cur), .i_k(k_cur), .o_vars(vars_nxt));

    // next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (acc && i_cmd.command == sha256_pkg::CMD_ABSORB && r_held == 6'd63) begin
                    n_state = sha256_pkg::ST_LOAD;
                    n_job   = sha256_pkg::JOB_ABSORB;
                end else if (acc && i_cmd.command == sha256_pkg::CMD_DIGEST) begin
                    n_state = sha256_pkg::ST_LOAD;
                    n_job   = sha256_pkg::JOB_PAD1;
                end
            end
            sha256_pkg::ST_LOAD:
                if (r_tail) n_state = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (r_cnt == 6'd63) n_state = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD: begin
                if (r_job == sha256_pkg::JOB_ABSORB) n_state = sha256_pkg::ST_IDLE;
                else if (r_job == sha256_pkg::JOB_PAD1 && r_held >= 6'd56) begin
                    n_state = sha256_pkg::ST_LOAD;
                    n_job   = sha256_pkg::JOB_PAD2;
                end else n_state = sha256_pkg::ST_EMIT;
            end
            sha256_pkg::ST_EMIT:
                if (o_dig.ready && r_oidx == 3'd7) n_state = sha256_pkg::ST_IDLE;
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_dig.valid       = (r_state == sha256_pkg::ST_EMIT);
        o_dig.digest_word = r_scr[r_oidx];
        o_dig.word_index  = r_oidx;
        o_dig.last_word   = (r_oidx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha256_pkg::ST_IDLE;
            r_job    <= sha256_pkg::JOB_ABSORB;
            r_hash   <= sha256_pkg::INIT_HASH;
            r_held   <= '0;
            r_bitlen <= '0;
            r_cnt    <= '0;
            r_oidx   <= '0;
            r_tail   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            unique case (r_state)
                sha256_pkg::ST_IDLE: begin
                    r_cnt  <= '0;
                    r_tail <= 1'b0;
                    r_oidx <= '0;
                    if (acc) begin
                        unique case (i_cmd.command)
                            sha256_pkg::CMD_BEGIN: begin
                                r_hash   <= sha256_pkg::INIT_HASH;
                                r_held   <= '0;
                                r_bitlen <= '0;
                            end
                            sha256_pkg::CMD_ABSORB: r_held <= r_held + 6'd1;
                            sha256_pkg::CMD_DIGEST: begin
                                r_len <= r_bitlen + {55'd0, r_held, 3'd0};
                                r_scr <= r_hash;
                            end
                            default: ;
                        endcase
                    end
                end
                sha256_pkg::ST_LOAD: begin
                    // first cycle only primes r_rd; window shifts on later cycles
                    if (r_cnt != 6'd0 || r_tail) begin
                        for (int j = 0; j < 15; j++)
                            r_win[j] <= {r_win[j][23:0], r_win[j + 1][31:24]};
                        r_win[15] <= w_load;
                    end
                    if (r_cnt == 6'd63 && !r_tail) begin
                        r_tail <= 1'b1;
                    end else if (r_tail) begin
                        r_cnt  <= '0;
                        r_tail <= 1'b0;
                        r_vars <= base;
                    end else r_cnt <= r_cnt + 6'd1;
                    // after the final shift word 0 sits in r_win[0], big-endian
                end
                sha256_pkg::ST_ROUND: begin
                    r_vars <= vars_nxt;
                    if (r_cnt >= 6'd16) begin
                        for (int j = 0; j < 15; j++) r_win[j] <= r_win[j + 1];
                        r_win[15] <= w_sched;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                sha256_pkg::ST_FOLD: begin
                    r_cnt <= '0;
                    for (int j = 0; j < 8; j++) begin
                        if (r_job == sha256_pkg::JOB_ABSORB)
                            r_hash[j] <= r_hash[j] + r_vars[j];
                        else
                            r_scr[j] <= r_scr[j] + r_vars[j];
                    end
                    if (r_job == sha256_pkg::JOB_ABSORB) begin
                        r_held   <= '0;
                        r_bitlen <= r_bitlen + 64'd512;
                    end
                end
                sha256_pkg::ST_EMIT:
                    if (o_dig.ready) r_oidx <= r_oidx + 3'd1;
                default: ;
            endcase
        end
    end
endmodule

### sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the hasher core, bound into the core module.
// ----------------------------------------------------------------------------
module sha256_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [31:0] dig_word,
    input logic [2:0]  dig_index,
    input logic        dig_last
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dig_valid |-> (dig_last == (dig_index == 3'd7))) else $error("last mark");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dig_valid && cmd_ready)) else $error("ready while emitting");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dig_valid && dig_ready && !dig_last |=> dig_valid && dig_index == $past(dig_index) + 3'd1)
        else $error("index order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dig_valid && !dig_ready |=> $stable(dig_word)) else $error("word unstable");
endmodule

bind sha256_byte_stream_hasher_core sha256_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_valid(i_cmd.valid), .cmd_ready(i_cmd.ready),
    .dig_valid(o_dig.valid), .dig_ready(o_dig.ready),
    .dig_word(o_dig.digest_word), .dig_index(o_dig.word_index),
    .dig_last(o_dig.last_word)
);

### tb/sv/sha256_tb_if.sv
// ----------------------------------------------------------------------------
// SHA-256 testbench channel note
// The channel interfaces come from the RTL; this file holds
// small shared helpers for the testbench.
// ----------------------------------------------------------------------------
package sha256_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    // upper bound on idle cycles drawn per word on either side
    localparam int MAX_IDLE = 12;
endpackage

### tb/sv/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Tracks the message state from accepted command words, predicts each
// digest, and compares every digest word against the predicted queue.
// ----------------------------------------------------------------------------
module sha256_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_dig_valid,
    input  logic        i_dig_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digests_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_dig_word;

    t_dig_word   digest_q[$];
    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    int          fill;
    logic [63:0] bit_len;
    int          mismatches;
    int          digests_seen;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of a 64-byte block into h
    function automatic void compress_block(inout logic [31:0] h [8],
                                           input logic [7:0] blk [64]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int j = 0; j < 8; j++) v[j] = h[j];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) h[j] = h[j] + v[j];
    endfunction

    function automatic void queue_digest();
        logic [31:0] h [8];
        logic [7:0]  pad [64];
        logic [63:0] len;
        int i;
        h = hash_state;
        pad = block_buf;
        i = fill;
        pad[i] = 8'h80;
        i++;
        if (i > 56) begin
            while (i < 64) begin pad[i] = 8'h00; i++; end
            compress_block(h, pad);
            i = 0;
        end
        while (i < 56) begin pad[i] = 8'h00; i++; end
        len = bit_len + 64'(fill) * 8;
        for (int k = 0; k < 8; k++) pad[56+k] = len[63-8*k -: 8];
        compress_block(h, pad);
        for (int k = 0; k < 8; k++)
            digest_q.push_back('{word: h[k], index: 3'(k), last: k == 7});
    endfunction

    initial begin
        mismatches = 0;
        digests_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) hash_state[j] = sha256_pkg::INIT_HASH[j];
            fill = 0;
            bit_len = '0;
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                case (sha256_pkg::t_cmd'(i_command))
                    sha256_pkg::CMD_BEGIN: begin
                        for (int j = 0; j < 8; j++)
                            hash_state[j] = sha256_pkg::INIT_HASH[j];
                        fill = 0;
                        bit_len = '0;
                    end
                    sha256_pkg::CMD_ABSORB: begin
                        block_buf[fill] = i_data_byte;
                        fill++;
                        if (fill == 64) begin
                            compress_block(hash_state, block_buf);
                            bit_len = bit_len + 64'd512;
                            fill = 0;
                        end
                    end
                    sha256_pkg::CMD_DIGEST: queue_digest();
                    default: ;
                endcase
            end
            if (i_dig_valid && i_dig_ready) begin
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d",
                                 i_digest_word, i_word_index);
                end else begin
                    t_dig_word e;
                    e = digest_q.pop_front();
                    if (e.word !== i_digest_word || e.index !== i_word_index
                        || e.last !== i_last_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.index, e.last, i_digest_word,
                                     i_word_index, i_last_word);
                    end
                    if (e.last) digests_seen++;
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_digests_seen = digests_seen;
    assign o_pending = digest_q.size();
endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// SHA-256 core testbench
// Drives begin/absorb/digest and unused command words with random gaps and digest
// back-pressure; a checker beside the core predicts and compares digests.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;   // idle cycles, well beyond two compressions

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha256_cmd_if cmd_if ();
    sha256_dig_if dig_if ();

    int fail_count, pending, digests_seen;
    int idle_cycles;
    int words_sent;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sha256_byte_stream_hasher_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_dig   (dig_if.source)
    );

    sha256_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_if.valid),
        .i_cmd_ready   (cmd_if.ready),
        .i_command     (cmd_if.command),
        .i_data_byte   (cmd_if.data_byte),
        .i_dig_valid   (dig_if.valid),
        .i_dig_ready   (dig_if.ready),
        .i_digest_word (dig_if.digest_word),
        .i_word_index  (dig_if.word_index),
        .i_last_word   (dig_if.last_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_digests_seen(digests_seen)
    );

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = sha256_pkg::CMD_NONE;
        cmd_if.data_byte = '0;
        dig_if.ready = 1'b0;
    end

    // Sink side: per word, drop ready for a random gap bounded by MAX_IDLE, then hold ready
    // until the word goes through. Some stretches run with no stall at all.
    initial begin
        int gap;
        bit eager;
        @(posedge i_clk iff i_rst_n);
        forever begin
            eager = ($urandom_range(0, 3) == 0);
            repeat (16) begin
                gap = eager ? 0 : $urandom_range(0, sha256_tb_pkg::MAX_IDLE);
                if (gap > 0) begin
                    dig_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                dig_if.ready <= 1'b1;
                @(posedge i_clk iff dig_if.valid);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (dig_if.valid && dig_if.ready))
                idle_cycles = 0;
            else if (i_rst_n)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    bit eager_src;

    // Send one command word; the idle gap goes ahead of it with valid low.
    task automatic send_word(input sha256_pkg::t_cmd c, input logic [7:0] b);
        int gap;
        gap = eager_src ? 0 : $urandom_range(0, sha256_tb_pkg::MAX_IDLE);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= c;
        cmd_if.data_byte <= b;
        @(posedge i_clk iff cmd_if.ready);
        words_sent++;
    endtask

    task automatic absorb_bytes(input int n, input bit fixed, input logic [7:0] val);
        for (int i = 0; i < n; i++)
            send_word(sha256_pkg::CMD_ABSORB, fixed ? val : 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int n, pick;
        words_sent = 0;
        eager_src = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message straight out of reset, unused command,
        // extreme byte values, and the padding boundaries at 55 and 56 bytes.
        send_word(sha256_pkg::CMD_DIGEST, 8'h00);
        send_word(sha256_pkg::CMD_NONE, 8'hff);
        send_word(sha256_pkg::CMD_BEGIN, 8'h00);
        send_word(sha256_pkg::CMD_ABSORB, 8'h00);
        send_word(sha256_pkg::CMD_ABSORB, 8'hff);
        send_word(sha256_pkg::CMD_DIGEST, 8'hff);
        send_word(sha256_pkg::CMD_NONE, 8'h5a);
        send_word(sha256_pkg::CMD_DIGEST, 8'ha5);   // repeat digest: state left untouched
        send_word(sha256_pkg::CMD_BEGIN, 8'hff);
        absorb_bytes(55, 1'b0, 8'h00);
        send_word(sha256_pkg::CMD_DIGEST, 8'h00);   // 55 bytes: padding fits one block
        send_word(sha256_pkg::CMD_ABSORB, 8'h61);
        send_word(sha256_pkg::CMD_DIGEST, 8'h00);   // 56 bytes: padding spills into two
        absorb_bytes(8, 1'b0, 8'h00);
        send_word(sha256_pkg::CMD_DIGEST, 8'h00);   // exactly one full block absorbed

        // Random: mostly well-formed messages with random lengths and
        // content, interleaved digests, sprinkled with noise commands.
        while (words_sent < 350) begin
            eager_src = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_word(sha256_pkg::CMD_BEGIN, 8'($urandom_range(0, 255)));
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 140)
                                                 : $urandom_range(0, 20);
                absorb_bytes(n, $urandom_range(0, 5) == 0, 8'hff);
                send_word(sha256_pkg::CMD_DIGEST, 8'($urandom_range(0, 255)));
            end else if (pick < 9) begin
                absorb_bytes($urandom_range(1, 10), 1'b0, 8'h00);
                send_word(sha256_pkg::CMD_DIGEST, 8'($urandom_range(0, 255)));
            end else begin
                send_word(sha256_pkg::t_cmd'(2'($urandom_range(0, 3))),
                          8'($urandom_range(0, 255)));
            end
        end
        cmd_if.valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);

        $display("sent %0d command words; %0d digests checked", words_sent, digests_seen);
        $display("covered empty, padding-boundary, multi-block and resumed messages");
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

### sim.f
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_round.sv
sv/sha256_byte_stream_hasher_core.sv
sv/sha256_checker.sv
tb/sv/sha256_tb_if.sv
tb/sv/sha256_checker.sv
tb/sv/tb.sv
